// File: hw/rtl/zsad_pkg.sv
// Shared constants, register codes and sequencer states for the z-score window detector.
`default_nettype none

package zsad_pkg;

    localparam int WINDOW_DEFAULT = 1024;

    localparam int SAMPLE_W  = 16;
    localparam int THR_W     = 8;
    localparam int MINH_W    = 11;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    // shared multiplier operand width
    localparam int MUL_W = 32;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET   = 8'd48;   // 3.0 in Q4.4
    localparam logic [MINH_W-1:0] MIN_HISTORY_RESET = 11'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HISTORY = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NX,
        S_XX,
        S_D2,
        S_S2,
        S_NQL,
        S_NQH,
        S_TT,
        S_OLD,
        S_VL,
        S_VH,
        S_RHS,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/zsad_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none

module zsad_mul (
    input  logic                           clk,
    input  logic [zsad_pkg::MUL_W-1:0]     a,
    input  logic [zsad_pkg::MUL_W-1:0]     b,
    output logic [2*zsad_pkg::MUL_W-1:0]   prod
);
    import zsad_pkg::*;

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: hw/rtl/zscore_window_anomaly_detector.sv
// Top level: sliding-window z-score anomaly detector with a shared multiplier sequencer.
// Usage:
//   Input channel (in_valid / in_stall, word = one signed 16-bit sample): a word is taken
//   when in_valid is high and in_stall is low. in_stall is high from the cycle after a
//   word is taken until its result has been loaded into the output register.
//   Output channel (out_valid / out_stall, word = anomaly_flag, history_ready,
//   anomaly_total): held steady while out_stall is high.
//   Config port (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 = threshold
//   (Q4.4), index 1 = min_history. cfg_ready is always high; write only while idle.
// A sample is accepted while idle, then runs 12 sequencer steps. Ten of the steps
//   issue one product to the single 32x32 multiplier; the products are n*x, x*x, d*d,
//   sum*sum, two halves of n*sumsq, thr*thr, old*old and two halves of var*thr^2.
//   The next sample is taken only after the current one has finished all steps.
// If the previous result is still stalled when a new one is finished, the sequencer
//   waits in its last step; the next word is accepted as soon as the result register
//   has been loaded, even if that result itself is still waiting.
// Reset: window empty, sums and anomaly count zero, threshold 3.0, min_history 100.
//   The sample memory is not cleared; a read-back slot is used only once the window is full.
`default_nettype none

module zscore_window_anomaly_detector #(
    parameter int WINDOW = zsad_pkg::WINDOW_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [zsad_pkg::SAMPLE_W-1:0] sample,
    // result output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                anomaly_flag,
    output logic                                history_ready,
    output logic [zsad_pkg::CNT_W-1:0]          anomaly_total,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [zsad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [zsad_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import zsad_pkg::*;

    // derived widths
    localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;  // slot address
    localparam int CW   = $clog2(WINDOW + 1);                 // fill count, 0..WINDOW
    localparam int SUMW = 17 + AW;                            // signed running sum
    localparam int ASW  = 16 + AW;                            // |sum|
    localparam int SQW  = 32 + AW;                            // sum of squares
    localparam int NXW  = CW + SAMPLE_W;                      // n*|x|
    localparam int DW   = 18 + AW;                            // signed n*x - sum
    localparam int ADW  = 17 + AW;                            // |n*x - sum|
    localparam int NSQW = CW + SQW;                           // n*sumsq, variance term
    localparam int RHSW = NSQW + 16;                          // var * thr^2
    localparam int HW   = (CW > MINH_W) ? CW : MINH_W;        // history compare

    // sequencer
    state_t state_reg, state_next;
    logic   done_fire;

    // architectural state
    logic [AW-1:0]              wp_reg;
    logic [CW-1:0]              fill_reg;
    logic signed [SUMW-1:0]     sum_reg, sum_next;
    logic [SQW-1:0]             sumsq_reg, sumsq_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [THR_W-1:0]           thr_reg;
    logic [MINH_W-1:0]          minh_reg;

    // per-sample working registers
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] rd_reg;
    logic [ADW-1:0]             ad_reg, ad_next;
    logic [2*SAMPLE_W-1:0]      xsq_reg;
    logic [2*SAMPLE_W-1:0]      oldsq_reg;
    logic [2*ADW-1:0]           d2_reg;
    logic [2*ASW-1:0]           s2_reg;
    logic [NSQW-1:0]            nsq_reg;
    logic [NSQW-1:0]            var_reg, var_next;
    logic [2*THR_W-1:0]         thr2_reg;
    logic [RHSW-1:0]            rhs_reg;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic                       anom_reg;
    logic                       hist_reg;

    // sample memory
    logic [SAMPLE_W-1:0]        win_mem [WINDOW];

    // multiplier
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [2*MUL_W-1:0]         prod;

    // helper values
    logic                       full;
    logic                       hist_ok;
    logic                       anom_now;
    logic [SAMPLE_W-1:0]        x_mag, old_mag;
    logic [ASW-1:0]             sum_mag;
    logic signed [SUMW-1:0]     neg_sum;
    logic signed [DW-1:0]       nx_s, sum_ext, d_val, d_abs;
    logic [RHSW-1:0]            lhs_ext;

    zsad_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign full    = (fill_reg == CW'(WINDOW));
    assign hist_ok = (HW'(fill_reg) >= HW'(minh_reg));

    // magnitudes of the signed operands
    assign x_mag   = x_reg[SAMPLE_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign old_mag = rd_reg[SAMPLE_W-1] ? (~rd_reg + 1'b1) : rd_reg;
    assign neg_sum = -sum_reg;
    assign sum_mag = sum_reg[SUMW-1] ? neg_sum[ASW-1:0] : sum_reg[ASW-1:0];

    // deviation d = n*x - sum from the registered n*|x|
    always_comb
    begin
        nx_s    = signed'({{(DW-NXW){1'b0}}, prod[NXW-1:0]});
        sum_ext = DW'(sum_reg);
        d_val   = x_reg[SAMPLE_W-1] ? (-nx_s - sum_ext) : (nx_s - sum_ext);
        d_abs   = d_val[DW-1] ? -d_val : d_val;
        ad_next = d_abs[ADW-1:0];
    end

    // variance term, clamped at zero
    assign var_next = (nsq_reg > NSQW'(s2_reg)) ? (nsq_reg - NSQW'(s2_reg)) : '0;

    // window update: evict the oldest sample once the window is full
    assign sum_next   = sum_reg - (full ? SUMW'(rd_reg) : '0) + SUMW'(x_reg);
    assign sumsq_next = sumsq_reg - (full ? SQW'(oldsq_reg) : '0) + SQW'(xsq_reg);

    // final test: d^2 * 256 > var * thr^2
    assign lhs_ext  = RHSW'({d2_reg, 8'd0});
    assign anom_now = hist_ok && (lhs_ext > rhs_reg);
    assign cnt_next = (anom_now && (cnt_reg != '1)) ? (cnt_reg + 1'b1) : cnt_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_NX;
            S_NX:    state_next = S_XX;
            S_XX:    state_next = S_D2;
            S_D2:    state_next = S_S2;
            S_S2:    state_next = S_NQL;
            S_NQL:   state_next = S_NQH;
            S_NQH:   state_next = S_TT;
            S_TT:    state_next = S_OLD;
            S_OLD:   state_next = S_VL;
            S_VL:    state_next = S_VH;
            S_VH:    state_next = S_RHS;
            S_RHS:   state_next = S_DONE;
            S_DONE:  if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operand select
    always_comb
    begin
        in_stall  = 1'b1;
        done_fire = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_NX:
            begin
                mul_a = MUL_W'(x_mag);
                mul_b = MUL_W'(fill_reg);
            end
            S_XX:
            begin
                mul_a = MUL_W'(x_mag);
                mul_b = MUL_W'(x_mag);
            end
            S_D2:
            begin
                mul_a = MUL_W'(ad_reg);
                mul_b = MUL_W'(ad_reg);
            end
            S_S2:
            begin
                mul_a = MUL_W'(sum_mag);
                mul_b = MUL_W'(sum_mag);
            end
            S_NQL:
            begin
                mul_a = MUL_W'(fill_reg);
                mul_b = sumsq_reg[31:0];
            end
            S_NQH:
            begin
                mul_a = MUL_W'(fill_reg);
                mul_b = MUL_W'(sumsq_reg[SQW-1:32]);
            end
            S_TT:
            begin
                mul_a = MUL_W'(thr_reg);
                mul_b = MUL_W'(thr_reg);
            end
            S_OLD:
            begin
                mul_a = MUL_W'(old_mag);
                mul_b = MUL_W'(old_mag);
            end
            S_VL:
            begin
                mul_a = var_reg[31:0];
                mul_b = MUL_W'(thr2_reg);
            end
            S_VH:
            begin
                mul_a = MUL_W'(var_reg[NSQW-1:32]);
                mul_b = MUL_W'(thr2_reg);
            end
            S_RHS:
            begin
            end
            S_DONE:
            begin
                done_fire = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (done_fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            cnt_reg       <= '0;
            thr_reg       <= THRESHOLD_RESET;
            minh_reg      <= MIN_HISTORY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD:   thr_reg  <= cfg_data[THR_W-1:0];
                    REG_MIN_HISTORY: minh_reg <= cfg_data[MINH_W-1:0];
                    default:         ;
                endcase
            end

            if (state_reg == S_VL)
                sum_reg <= sum_next;
            if (state_reg == S_VH)
                sumsq_reg <= sumsq_next;

            if (done_fire)
            begin
                cnt_reg <= cnt_next;
                wp_reg  <= (wp_reg == AW'(WINDOW - 1)) ? '0 : (wp_reg + 1'b1);
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            x_reg <= sample;
        if (state_reg == S_XX)
            ad_reg <= ad_next;
        if (state_reg == S_D2)
            xsq_reg <= prod[2*SAMPLE_W-1:0];
        if (state_reg == S_S2)
            d2_reg <= prod[2*ADW-1:0];
        if (state_reg == S_NQL)
            s2_reg <= prod[2*ASW-1:0];
        if (state_reg == S_NQH)
            nsq_reg <= prod[NSQW-1:0];
        if (state_reg == S_TT)
            nsq_reg <= nsq_reg + {prod[NSQW-33:0], 32'd0};
        if (state_reg == S_OLD)
        begin
            thr2_reg <= prod[2*THR_W-1:0];
            var_reg  <= var_next;
        end
        if (state_reg == S_VL)
            oldsq_reg <= prod[2*SAMPLE_W-1:0];
        if (state_reg == S_VH)
            rhs_reg <= {{(RHSW-48){1'b0}}, prod[47:0]};
        if (state_reg == S_RHS)
            rhs_reg <= rhs_reg + {prod[NSQW-17:0], 32'd0};
        if (done_fire)
        begin
            anom_reg <= anom_now;
            hist_reg <= hist_ok;
        end
    end

    // sample memory: one write at the end of a sample, oldest slot read back every cycle
    always_ff @(posedge clk)
    begin
        if (done_fire)
            win_mem[wp_reg] <= x_reg;
        rd_reg <= signed'(win_mem[wp_reg]);
    end

    assign out_valid     = out_valid_reg;
    assign anomaly_flag  = anom_reg;
    assign history_ready = hist_reg;
    assign anomaly_total = cnt_reg;
    assign cfg_ready     = 1'b1;

`ifndef NO_ASSERTIONS
    // an anomaly is only flagged when the history test passed
    a_anom_needs_hist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && anomaly_flag) |-> history_ready)
        else $error("anomaly flagged without history");

    // counter moves only at the end of a sample and only by one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (($past(state_reg) == S_DONE) && (cnt_reg == $past(cnt_reg) + 32'd1)))
        else $error("anomaly counter stepped wrongly");

    // while filling, the write slot tracks the fill count
    a_wp_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < CW'(WINDOW)) |-> (wp_reg == fill_reg[AW-1:0]))
        else $error("write slot out of step with fill count");

    // fill count grows by one per finished sample until the window is full
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done_fire && !full) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance");
`endif

endmodule

`default_nettype wire
